FILE: design/gamepad_serial_frame_master_core_defines.svh
// Assertion macros for the gamepad serial frame master core.
`ifndef GAMEPAD_SERIAL_FRAME_MASTER_CORE_DEFINES_SVH
`define GAMEPAD_SERIAL_FRAME_MASTER_CORE_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define GSFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define GSFM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/gsfm_pkg.sv
// Shared widths, defaults and constants of the gamepad serial frame master.
`default_nettype none
package gsfm_pkg;

  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int BYTE_W       = 8;
  localparam int CNT_W        = 3;
  localparam int RX_INDEX_W   = 6;
  localparam int NUM_IN_BYTES = 4;

  localparam int MAX_CMD_BYTES_DEF = 4;
  localparam int FRAME_BYTES_DEF   = 34;

  localparam logic [CFG_W-1:0] HALF_PERIOD_RESET = 16'd100;
  localparam logic [CFG_W-1:0] WAIT_RESET        = 16'd500;

  localparam logic [BYTE_W-1:0] TX_HEADER_BYTE = 8'h01;
  localparam logic [BYTE_W-1:0] TX_FILL_BYTE   = 8'h00;
  localparam logic [3:0]        LEN_NIBBLE_MASK = 4'hF;
  localparam logic [6:0]        LEN_BASE        = 7'd3;

endpackage
`default_nettype wire

FILE: design/gsfm_in_if.sv
// Request channel into the frame master: one tick request per transfer.
`default_nettype none
interface gsfm_in_if import gsfm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic              data_in;
  logic [BYTE_W-1:0] cmd_byte0;
  logic [BYTE_W-1:0] cmd_byte1;
  logic [BYTE_W-1:0] cmd_byte2;
  logic [BYTE_W-1:0] cmd_byte3;
  logic [CNT_W-1:0]  cmd_count;

  modport source (output valid, kind, data_in, cmd_byte0, cmd_byte1, cmd_byte2,
                  cmd_byte3, cmd_count, input ready);
  modport sink (input valid, kind, data_in, cmd_byte0, cmd_byte1, cmd_byte2,
                cmd_byte3, cmd_count, output ready);
endinterface
`default_nettype wire

FILE: design/gsfm_out_if.sv
// Result channel out of the frame master: pin levels and received bytes.
`default_nettype none
interface gsfm_out_if import gsfm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  att_out;
  logic                  cmd_out;
  logic                  clk_out;
  logic                  rx_valid;
  logic [BYTE_W-1:0]     rx_byte;
  logic [RX_INDEX_W-1:0] rx_index;
  logic                  busy_res;
  logic                  done_res;

  modport source (output valid, att_out, cmd_out, clk_out, rx_valid, rx_byte,
                  rx_index, busy_res, done_res, input ready);
  modport sink (input valid, att_out, cmd_out, clk_out, rx_valid, rx_byte,
                rx_index, busy_res, done_res, output ready);
endinterface
`default_nettype wire

FILE: design/gamepad_serial_frame_master_core.sv
// Top level of the gamepad serial frame master: frame sequencer and result buffer.
//
// Every request on in_ch stands for one clock tick of the controller link. A
// request with kind set while idle latches the command bytes and opens a frame;
// at any other time it only advances the running frame. For every accepted
// request exactly one result leaves on out_ch, carrying the attention, command
// and serial clock levels after that tick, a received byte when one completes,
// and the busy and done flags.
// The result of a request is registered in the output register, or in the skid
// register while out_ch stalls. Throughput: one request per cycle while in_ch.ready
// is high, set by the single registered pass of the sequencer from state register to result.
// When out_ch stalls, the held result stays in the output register and one
// more request is still taken into a skid register; in_ch.ready then drops
// until the receiver takes a result.
// Reset (synchronous, rst_n low) puts the sequencer in idle with all lines
// high, empties both result registers and loads the timing registers with
// 100 ticks per half period and 500 ticks per guard wait.
// cfg_we writes register cfg_index: 0 is the half period, 1 the guard wait.
// A zero in either register counts as one tick.
`default_nettype none
`include "gamepad_serial_frame_master_core_defines.svh"
module gamepad_serial_frame_master_core
  import gsfm_pkg::*;
#(
  parameter int MAX_CMD_BYTES = MAX_CMD_BYTES_DEF,
  parameter int FRAME_BYTES   = FRAME_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  gsfm_in_if.sink                   in_ch,
  gsfm_out_if.source                out_ch
);

  localparam int CC_W     = $clog2(MAX_CMD_BYTES + 1);
  localparam int CS_IDX_W = (MAX_CMD_BYTES > 1) ? $clog2(MAX_CMD_BYTES) : 1;
  localparam int FL_W     = $clog2(FRAME_BYTES + 1);
  localparam logic [3:0] MAX_CNT  = 4'(MAX_CMD_BYTES);
  localparam logic [6:0] MAX_LEN  = 7'(FRAME_BYTES);

  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT        = 1'b1;

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_ATT_WAIT  = 6'b000010,
    PH_CLK_LOW   = 6'b000100,
    PH_CLK_HIGH  = 6'b001000,
    PH_BYTE_WAIT = 6'b010000,
    PH_END_WAIT  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic                  att_out;
    logic                  cmd_out;
    logic                  clk_out;
    logic                  rx_valid;
    logic [BYTE_W-1:0]     rx_byte;
    logic [RX_INDEX_W-1:0] rx_index;
    logic                  busy_res;
    logic                  done_res;
  } res_t;

  // Timing registers.
  logic [CFG_W-1:0] half_period_r;
  logic [CFG_W-1:0] wait_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RESET;
      wait_r        <= WAIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_PERIOD: half_period_r <= cfg_data;
        REG_WAIT:        wait_r        <= cfg_data;
        default:         ;
      endcase
    end
  end

  logic [CFG_W-1:0] half_ticks;
  logic [CFG_W-1:0] wait_ticks;
  assign half_ticks = (half_period_r == '0) ? CFG_W'(1) : half_period_r;
  assign wait_ticks = (wait_r == '0) ? CFG_W'(1) : wait_r;

  // Sequencer state.
  phase_t                phase_r, phase_nxt;
  logic [CFG_W-1:0]      delay_count_r, delay_count_nxt;
  logic [2:0]            bit_index_r, bit_index_nxt;
  logic [RX_INDEX_W-1:0] byte_index_r, byte_index_nxt;
  logic [FL_W-1:0]       frame_length_r, frame_length_nxt;
  logic [BYTE_W-1:0]     tx_shift_r, tx_shift_nxt;
  logic [BYTE_W-1:0]     rx_shift_r, rx_shift_nxt;
  logic [CC_W-1:0]       cmd_count_r, cmd_count_nxt;
  logic [BYTE_W-1:0]     cmd_store_r [MAX_CMD_BYTES];

  logic                  in_acc;
  logic                  start_ok;
  logic [BYTE_W-1:0]     in_bytes [NUM_IN_BYTES];
  logic [3:0]            cnt_sat;
  logic [RX_INDEX_W-1:0] tx_idx;
  logic [RX_INDEX_W-1:0] tx_idx_m1;
  logic [BYTE_W-1:0]     tx_pick;
  logic [6:0]            len_rx;
  logic [6:0]            len_cmd;
  logic [6:0]            len_max;
  logic [6:0]            len_fin;
  logic                  more_bytes;
  res_t                  res;

  assign in_bytes[0] = in_ch.cmd_byte0;
  assign in_bytes[1] = in_ch.cmd_byte1;
  assign in_bytes[2] = in_ch.cmd_byte2;
  assign in_bytes[3] = in_ch.cmd_byte3;

  assign start_ok = (phase_r == PH_IDLE) && in_ch.kind;

  // A count of zero still sends command byte 0; counts above MAX_CMD_BYTES saturate.
  always_comb begin
    cnt_sat = 4'(in_ch.cmd_count);
    if (cnt_sat == 4'd0) begin
      cnt_sat = 4'd1;
    end
    if (cnt_sat > MAX_CNT) begin
      cnt_sat = MAX_CNT;
    end
  end

  // Byte to send next: the header, a stored command byte, or fill.
  assign tx_idx    = (phase_r == PH_BYTE_WAIT) ? byte_index_r + RX_INDEX_W'(1) : byte_index_r;
  assign tx_idx_m1 = tx_idx - RX_INDEX_W'(1);

  always_comb begin
    if (tx_idx == '0) begin
      tx_pick = TX_HEADER_BYTE;
    end else if (7'(tx_idx) <= 7'(cmd_count_r)) begin
      tx_pick = cmd_store_r[tx_idx_m1[CS_IDX_W-1:0]];
    end else begin
      tx_pick = TX_FILL_BYTE;
    end
  end

  // Frame length: byte 1 length nibble, at least cmd count + 1, capped at FRAME_BYTES.
  assign len_rx  = {2'b00, rx_shift_r[3:0] & LEN_NIBBLE_MASK, 1'b0} + LEN_BASE;
  assign len_cmd = 7'(cmd_count_r) + 7'd1;
  assign len_max = (len_cmd > len_rx) ? len_cmd : len_rx;
  assign len_fin = (len_max > MAX_LEN) ? MAX_LEN : len_max;

  assign more_bytes = (byte_index_r == '0) ||
                      ((7'(byte_index_r) + 7'd1) < 7'(frame_length_r));

  always_comb begin
    phase_nxt        = phase_r;
    delay_count_nxt  = delay_count_r;
    bit_index_nxt    = bit_index_r;
    byte_index_nxt   = byte_index_r;
    frame_length_nxt = frame_length_r;
    tx_shift_nxt     = tx_shift_r;
    rx_shift_nxt     = rx_shift_r;
    cmd_count_nxt    = cmd_count_r;
    res              = '0;

    if (phase_r == PH_IDLE) begin
      if (in_ch.kind) begin
        cmd_count_nxt    = CC_W'(cnt_sat);
        byte_index_nxt   = '0;
        frame_length_nxt = '0;
        phase_nxt        = PH_ATT_WAIT;
        delay_count_nxt  = wait_ticks;
      end
    end else if (delay_count_r > CFG_W'(1)) begin
      delay_count_nxt = delay_count_r - CFG_W'(1);
    end else begin
      case (phase_r)
        PH_ATT_WAIT: begin
          tx_shift_nxt    = tx_pick;
          rx_shift_nxt    = '0;
          bit_index_nxt   = '0;
          phase_nxt       = PH_CLK_LOW;
          delay_count_nxt = half_ticks;
        end
        PH_CLK_LOW: begin
          rx_shift_nxt    = rx_shift_r | (BYTE_W'(in_ch.data_in) << bit_index_r);
          phase_nxt       = PH_CLK_HIGH;
          delay_count_nxt = half_ticks;
        end
        PH_CLK_HIGH: begin
          if (bit_index_r == 3'd7) begin
            res.rx_valid = 1'b1;
            res.rx_byte  = rx_shift_r;
            res.rx_index = byte_index_r;
            if (byte_index_r == RX_INDEX_W'(1)) begin
              frame_length_nxt = len_fin[FL_W-1:0];
            end
            phase_nxt       = PH_BYTE_WAIT;
            delay_count_nxt = wait_ticks;
          end else begin
            bit_index_nxt   = bit_index_r + 3'd1;
            phase_nxt       = PH_CLK_LOW;
            delay_count_nxt = half_ticks;
          end
        end
        PH_BYTE_WAIT: begin
          if (more_bytes) begin
            byte_index_nxt  = tx_idx;
            tx_shift_nxt    = tx_pick;
            rx_shift_nxt    = '0;
            bit_index_nxt   = '0;
            phase_nxt       = PH_CLK_LOW;
            delay_count_nxt = half_ticks;
          end else begin
            phase_nxt       = PH_END_WAIT;
            delay_count_nxt = wait_ticks;
          end
        end
        default: begin
          phase_nxt       = PH_IDLE;
          delay_count_nxt = '0;
          res.done_res    = 1'b1;
        end
      endcase
    end

    // Line levels follow the state after this tick.
    res.att_out  = 1'b1;
    res.cmd_out  = 1'b1;
    res.clk_out  = 1'b1;
    if ((phase_nxt == PH_ATT_WAIT) || (phase_nxt == PH_BYTE_WAIT)) begin
      res.att_out = 1'b0;
    end else if ((phase_nxt == PH_CLK_LOW) || (phase_nxt == PH_CLK_HIGH)) begin
      res.att_out = 1'b0;
      res.cmd_out = tx_shift_nxt[bit_index_nxt];
      res.clk_out = (phase_nxt == PH_CLK_HIGH);
    end
    res.busy_res = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      delay_count_r  <= '0;
      bit_index_r    <= '0;
      byte_index_r   <= '0;
      frame_length_r <= '0;
      tx_shift_r     <= '0;
      rx_shift_r     <= '0;
      cmd_count_r    <= '0;
    end else if (in_acc) begin
      phase_r        <= phase_nxt;
      delay_count_r  <= delay_count_nxt;
      bit_index_r    <= bit_index_nxt;
      byte_index_r   <= byte_index_nxt;
      frame_length_r <= frame_length_nxt;
      tx_shift_r     <= tx_shift_nxt;
      rx_shift_r     <= rx_shift_nxt;
      cmd_count_r    <= cmd_count_nxt;
    end
  end

  // Command bytes are latched by a start; entries past the input bytes get fill.
  for (genvar g = 0; g < MAX_CMD_BYTES; g++) begin : g_store
    always_ff @(posedge clk) begin
      if (in_acc && start_ok) begin
        if (g < NUM_IN_BYTES) begin
          cmd_store_r[g] <= in_bytes[g % NUM_IN_BYTES];
        end else begin
          cmd_store_r[g] <= TX_FILL_BYTE;
        end
      end
    end
  end

  // Output register with a skid register behind it.
  res_t main_r;
  res_t skid_r;
  logic main_valid_r;
  logic skid_valid_r;

  assign in_ch.ready = !skid_valid_r;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ch.ready || !main_valid_r) begin
      main_valid_r <= skid_valid_r || in_acc;
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ch.ready || !main_valid_r) begin
      main_r <= skid_valid_r ? skid_r : res;
    end else if (in_acc) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid    = main_valid_r;
  assign out_ch.att_out  = main_r.att_out;
  assign out_ch.cmd_out  = main_r.cmd_out;
  assign out_ch.clk_out  = main_r.clk_out;
  assign out_ch.rx_valid = main_r.rx_valid;
  assign out_ch.rx_byte  = main_r.rx_byte;
  assign out_ch.rx_index = main_r.rx_index;
  assign out_ch.busy_res = main_r.busy_res;
  assign out_ch.done_res = main_r.done_res;

  `GSFM_ASSERT(a_skid_behind_main, !skid_valid_r || main_valid_r, "skid full with output empty")
  `GSFM_ASSERT(a_idle_no_delay, (phase_r != PH_IDLE) || (delay_count_r == '0), "idle with delay")
  `GSFM_ASSERT(a_busy_delay_set, (phase_r == PH_IDLE) || (delay_count_r != '0), "busy, zero delay")
  `GSFM_ASSERT(a_start_opens, (in_acc && start_ok) |=> (phase_r == PH_ATT_WAIT), "start lost")
  `GSFM_ASSERT(a_len_bound, 7'(frame_length_r) <= MAX_LEN, "frame length too large")

endmodule
`default_nettype wire

FILE: tb/gsfm_tb_pkg.sv
// Request and result types plus the tick-accurate frame scoreboard for the frame master bench.
`timescale 1ns / 100ps
package gsfm_tb_pkg;
  import gsfm_pkg::*;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_ATT_WAIT,
    SEQ_CLK_LOW,
    SEQ_CLK_HIGH,
    SEQ_BYTE_WAIT,
    SEQ_END_WAIT
  } seq_phase_e;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_WAIT  = 1'b1;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  localparam int MAX_CMD   = MAX_CMD_BYTES_DEF;
  localparam int FRAME_MAX = FRAME_BYTES_DEF;

  typedef struct packed {
    logic                                 kind;
    logic                                 data_in;
    logic [NUM_IN_BYTES-1:0][BYTE_W-1:0]  cmd_bytes;
    logic [CNT_W-1:0]                     cmd_count;
  } tick_t;

  typedef struct packed {
    logic                  att;
    logic                  cmd;
    logic                  sclk;
    logic                  rx_valid;
    logic [BYTE_W-1:0]     rx_byte;
    logic [RX_INDEX_W-1:0] rx_index;
    logic                  busy;
    logic                  done;
  } pins_t;

  class frame_scoreboard;
    logic [CFG_W-1:0]  half_ticks;
    logic [CFG_W-1:0]  guard_ticks;
    seq_phase_e        phase;
    int unsigned       delay_left;
    int unsigned       bit_pos;
    int unsigned       byte_pos;
    int unsigned       frame_len;
    int unsigned       cmd_total;
    logic [BYTE_W-1:0] tx_bits;
    logic [BYTE_W-1:0] rx_bits;
    logic [BYTE_W-1:0] cmd_mem [MAX_CMD];
    pins_t             pins_due [$];
    int unsigned       mismatches;

    function new();
      half_ticks  = HALF_PERIOD_RESET;
      guard_ticks = WAIT_RESET;
      phase       = SEQ_IDLE;
      delay_left  = 0;
      bit_pos     = 0;
      byte_pos    = 0;
      frame_len   = 0;
      cmd_total   = 0;
      tx_bits     = '0;
      rx_bits     = '0;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_HALF_PERIOD) half_ticks = val;
      else guard_ticks = val;
    endfunction

    function int unsigned outstanding();
      return pins_due.size();
    endfunction

    // A zero timing register still lasts one tick.
    function int unsigned span(logic [CFG_W-1:0] v);
      return (v == 0) ? 1 : int'(v);
    endfunction

    function void load_byte();
      if (byte_pos == 0) tx_bits = TX_HEADER_BYTE;
      else if (byte_pos <= cmd_total && byte_pos - 1 < MAX_CMD) tx_bits = cmd_mem[byte_pos - 1];
      else tx_bits = TX_FILL_BYTE;
      rx_bits    = '0;
      bit_pos    = 0;
      phase      = SEQ_CLK_LOW;
      delay_left = span(half_ticks);
    endfunction

    // Advances the link by one accepted tick and queues the pin levels it leaves.
    function void note_tick(tick_t t);
      pins_t       r;
      int unsigned n;
      r = '0;
      if (phase == SEQ_IDLE) begin
        if (t.kind == KIND_START) begin
          for (int i = 0; i < MAX_CMD; i++) begin
            cmd_mem[i] = (i < NUM_IN_BYTES) ? t.cmd_bytes[i] : TX_FILL_BYTE;
          end
          if (t.cmd_count == 0) cmd_total = 1;
          else if (t.cmd_count > MAX_CMD) cmd_total = MAX_CMD;
          else cmd_total = t.cmd_count;
          byte_pos   = 0;
          frame_len  = 0;
          phase      = SEQ_ATT_WAIT;
          delay_left = span(guard_ticks);
        end
      end else if (delay_left > 1) begin
        delay_left--;
      end else begin
        case (phase)
          SEQ_ATT_WAIT: load_byte();
          SEQ_CLK_LOW: begin
            rx_bits[bit_pos] = t.data_in;
            phase      = SEQ_CLK_HIGH;
            delay_left = span(half_ticks);
          end
          SEQ_CLK_HIGH: begin
            if (bit_pos >= 7) begin
              r.rx_valid = 1'b1;
              r.rx_byte  = rx_bits;
              r.rx_index = byte_pos[RX_INDEX_W-1:0];
              if (byte_pos == 1) begin
                n = (rx_bits[3:0] & LEN_NIBBLE_MASK) * 2 + LEN_BASE;
                if (cmd_total + 1 > n) n = cmd_total + 1;
                if (n > FRAME_MAX) n = FRAME_MAX;
                frame_len = n;
              end
              phase      = SEQ_BYTE_WAIT;
              delay_left = span(guard_ticks);
            end else begin
              bit_pos++;
              phase      = SEQ_CLK_LOW;
              delay_left = span(half_ticks);
            end
          end
          SEQ_BYTE_WAIT: begin
            if (byte_pos == 0 || byte_pos + 1 < frame_len) begin
              byte_pos++;
              load_byte();
            end else begin
              phase      = SEQ_END_WAIT;
              delay_left = span(guard_ticks);
            end
          end
          default: begin
            phase      = SEQ_IDLE;
            delay_left = 0;
            r.done     = 1'b1;
          end
        endcase
      end

      r.att  = 1'b1;
      r.cmd  = 1'b1;
      r.sclk = 1'b1;
      if (phase == SEQ_ATT_WAIT || phase == SEQ_BYTE_WAIT) begin
        r.att = 1'b0;
      end else if (phase == SEQ_CLK_LOW || phase == SEQ_CLK_HIGH) begin
        r.att  = 1'b0;
        r.cmd  = tx_bits[bit_pos];
        r.sclk = (phase == SEQ_CLK_HIGH);
      end
      r.busy = (phase != SEQ_IDLE);
      pins_due.push_back(r);
    endfunction

    function void compare(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (got !== want) begin
        $error("%s expected %0h actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_pins(pins_t got);
      pins_t want;
      if (pins_due.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
        return;
      end
      want = pins_due.pop_front();
      compare("att_out", want.att, got.att);
      compare("cmd_out", want.cmd, got.cmd);
      compare("clk_out", want.sclk, got.sclk);
      compare("rx_valid", want.rx_valid, got.rx_valid);
      compare("rx_byte", want.rx_byte, got.rx_byte);
      compare("rx_index", want.rx_index, got.rx_index);
      compare("busy_res", want.busy, got.busy);
      compare("done_res", want.done, got.done);
    endfunction
  endclass

endpackage

FILE: tb/tb.sv
// Frame master bench: drives tick requests, writes timing registers and checks every result.
`timescale 1ns / 100ps
module tb;
  import gsfm_pkg::*;
  import gsfm_tb_pkg::*;

  // Generous ceiling on the run, which has both sides idling a quarter of the time.
  localparam int unsigned CYCLE_LIMIT = 100_000;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  gsfm_in_if  in_ch ();
  gsfm_out_if out_ch ();

  gamepad_serial_frame_master_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  frame_scoreboard   sb;
  bit                steady;       // When set, neither side inserts idle cycles.
  logic [BYTE_W-1:0] reply_byte1;  // Byte the controller returns at frame position 1.
  int unsigned       ticks_sent;
  int unsigned       cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The run is cut off here if the block stops handshaking.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[gamepad_serial_frame_master_core] ERROR");
      $finish;
    end
  end

  // The result receiver stalls about one cycle in four unless a steady stretch is running.
  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 25);
  end

  // Every accepted result is checked against the oldest predicted pin state.
  always @(posedge clk) begin
    pins_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.att      = out_ch.att_out;
      got.cmd      = out_ch.cmd_out;
      got.sclk     = out_ch.clk_out;
      got.rx_valid = out_ch.rx_valid;
      got.rx_byte  = out_ch.rx_byte;
      got.rx_index = out_ch.rx_index;
      got.busy     = out_ch.busy_res;
      got.done     = out_ch.done_res;
      sb.check_pins(got);
    end
  end

  // Builds the next tick from the predicted link state. While byte 1 of a frame is being
  // clocked, the data line plays back reply_byte1 so that the frame length is steered;
  // everywhere else the data line is random. A busy frame sometimes sees a stray start.
  function automatic tick_t random_tick();
    tick_t t;
    t.cmd_bytes = $urandom;
    t.cmd_count = $urandom_range(7);
    t.kind = (sb.phase != SEQ_IDLE && $urandom_range(99) < 3) ? KIND_START : KIND_TICK;
    if (sb.phase == SEQ_CLK_LOW && sb.byte_pos == 1) t.data_in = reply_byte1[sb.bit_pos];
    else t.data_in = $urandom_range(1);
    return t;
  endfunction

  // Presents one tick request and waits for it to be taken. Valid stays high afterwards so
  // that back-to-back requests never lower and raise it within one time step.
  task automatic push_tick(input tick_t t);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= t.kind;
    in_ch.data_in   <= t.data_in;
    in_ch.cmd_byte0 <= t.cmd_bytes[0];
    in_ch.cmd_byte1 <= t.cmd_bytes[1];
    in_ch.cmd_byte2 <= t.cmd_bytes[2];
    in_ch.cmd_byte3 <= t.cmd_bytes[3];
    in_ch.cmd_count <= t.cmd_count;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_tick(t);
    ticks_sent++;
  endtask

  // Timing registers change only with every result drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Opens a frame from idle and keeps ticking until the sequencer is back in idle.
  task automatic run_frame(input logic [NUM_IN_BYTES-1:0][BYTE_W-1:0] bytes,
                           input logic [CNT_W-1:0] count, input logic [BYTE_W-1:0] reply);
    tick_t t;
    reply_byte1 = reply;
    t = random_tick();
    t.kind      = KIND_START;
    t.cmd_bytes = bytes;
    t.cmd_count = count;
    push_tick(t);
    while (sb.phase != SEQ_IDLE) push_tick(random_tick());
  endtask

  // Opens a frame on the reset timing. Once the attention wait is over and the first half
  // period is running at its reset length, the fastest timing is loaded for the rest.
  task automatic run_reset_frame();
    tick_t t;
    reply_byte1 = 8'h00;
    t = random_tick();
    t.kind      = KIND_START;
    t.cmd_bytes = {8'h5A, 8'hC3, 8'hFF, 8'h00};
    t.cmd_count = 3'd1;
    push_tick(t);
    repeat (505) push_tick(random_tick());
    write_reg(REG_HALF_PERIOD, 16'd1);
    write_reg(REG_GUARD_WAIT, 16'd1);
    while (sb.phase != SEQ_IDLE) push_tick(random_tick());
  endtask

  // Random frames under one timing setting. Counts stay mostly in the legal range and the
  // reply nibble is mostly small so that many short frames fit, with long ones mixed in.
  task automatic run_frames(input logic [CFG_W-1:0] half, input logic [CFG_W-1:0] guard,
                            input int unsigned budget);
    int unsigned      start_ticks;
    logic [CNT_W-1:0] cnt;
    logic [BYTE_W-1:0] reply;
    write_reg(REG_HALF_PERIOD, half);
    write_reg(REG_GUARD_WAIT, guard);
    start_ticks = ticks_sent;
    while (ticks_sent - start_ticks < budget) begin
      cnt = ($urandom_range(99) < 75) ? $urandom_range(1, 4) : $urandom_range(7);
      reply = $urandom;
      if ($urandom_range(99) < 70) reply[3:0] = $urandom_range(2);
      run_frame($urandom, cnt, reply);
      repeat ($urandom_range(4)) push_tick(random_tick());
    end
  endtask

  initial begin
    sb          = new();
    steady      = 1'b0;
    reply_byte1 = '0;
    ticks_sent  = 0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_HALF_PERIOD;
    cfg_data    = '0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_TICK;
    in_ch.data_in   = 1'b0;
    in_ch.cmd_byte0 = '0;
    in_ch.cmd_byte1 = '0;
    in_ch.cmd_byte2 = '0;
    in_ch.cmd_byte3 = '0;
    in_ch.cmd_count = '0;
    out_ch.ready    = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // One frame that starts on the reset timing and ends on the fastest timing.
    run_reset_frame();
    // A count of zero still sends command byte 0.
    run_frame({8'h00, 8'h00, 8'h00, 8'h00}, 3'd0, 8'hF0);
    // All-ones command bytes, and a reply nibble of 15 gives the longest frame.
    run_frame({8'hFF, 8'hFF, 8'hFF, 8'hFF}, 3'd4, 8'hFF);
    // Counts above four saturate, and the count then sets the length over the reply.
    run_frame({8'hA5, 8'h5A, 8'h0F, 8'hF0}, 3'd7, 8'h00);
    run_frame({8'h9A, 8'hBC, 8'hDE, 8'hF1}, 3'd2, 8'h00);
    // Zero in either timing register behaves as a single tick.
    write_reg(REG_HALF_PERIOD, 16'd0);
    write_reg(REG_GUARD_WAIT, 16'd0);
    run_frame({8'hC0, 8'h3C, 8'h03, 8'h81}, 3'd4, 8'h03);
    // Largest timing values, only idled through, since a full frame at them would be very long.
    write_reg(REG_HALF_PERIOD, 16'hFFFF);
    write_reg(REG_GUARD_WAIT, 16'hFFFF);
    repeat (5) push_tick(random_tick());

    // Random frames under several small timings; the second runs without idling on either side.
    run_frames(16'd2, 16'd1, 80);
    steady = 1'b1;
    run_frames(16'd1, 16'd3, 150);
    steady = 1'b0;
    run_frames(16'd0, 16'd0, 80);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    // A few extra cycles catch any result the block sends beyond the last request.
    repeat (8) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("[gamepad_serial_frame_master_core] OK");
    end else begin
      $display("[gamepad_serial_frame_master_core] ERROR");
    end
    $finish;
  end

endmodule
